// ===== src/assert_macros.svh =====
// assertion macros used by the packer top
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("assertion failed");

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, prop)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== src/hcbp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package hcbp_pkg;

  // field widths of the item channels
  localparam int unsigned REQ_W        = 2;
  localparam int unsigned SYM_W        = 8;
  localparam int unsigned CODE_FIELD_W = 16;
  localparam int unsigned LEN_FIELD_W  = 5;
  localparam int unsigned BYTE_W       = 8;

  // packer state widths
  localparam int unsigned PEND_W = 7;
  localparam int unsigned CNT_W  = 3;
  localparam int unsigned TOT_W  = 5;

  // parameter defaults
  localparam int unsigned MAX_CODE_LEN_DEF  = 16;
  localparam int unsigned ALPHABET_SIZE_DEF = 256;

  // request codes
  localparam logic [REQ_W-1:0] REQ_LOAD   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_ENCODE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_FLUSH  = 2'd2;

endpackage

`default_nettype wire

// ===== src/hcbp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

// request channel
interface hcbp_in_if;
  logic                                   valid;
  logic                                   ready;
  logic [hcbp_pkg::REQ_W-1:0]             req_type;
  logic [hcbp_pkg::SYM_W-1:0]             symbol;
  logic [hcbp_pkg::CODE_FIELD_W-1:0]      code_bits;
  logic [hcbp_pkg::LEN_FIELD_W-1:0]       code_len;

  modport source (output valid, req_type, symbol, code_bits, code_len, input ready);
  modport sink   (input valid, req_type, symbol, code_bits, code_len, output ready);
endinterface

// packed byte channel
interface hcbp_out_if;
  logic                          valid;
  logic                          ready;
  logic [hcbp_pkg::BYTE_W-1:0]   packed_byte;
  logic                          is_last;

  modport source (output valid, packed_byte, is_last, input ready);
  modport sink   (input valid, packed_byte, is_last, output ready);
endinterface

`default_nettype wire

// ===== src/hcbp_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hcbp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AddrW = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             wr_en_i,
  input  wire logic [AddrW-1:0] wr_addr_i,
  input  wire logic [WIDTH-1:0] wr_data_i,
  input  wire logic             rd_en_i,
  input  wire logic [AddrW-1:0] rd_addr_i,
  output logic      [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

// ===== src/huffman_code_bit_packer_top.sv =====
// Huffman code bit packer.
// in_i carries requests: a load writes one code table entry (code bits and
// length for a symbol), an encode appends the symbol's code to the byte being
// filled from bit 7 down, a flush sends the partial byte zero padded.
// out_o carries completed bytes; is_last marks the final byte of a request.
// A load writes its table entry and gives no byte. An encode reads the
// table in the cycle it is taken; the read data is registered, and the
// packing step runs once the output register is free, so its first byte
// shows on out_o from the output register. A flush goes through the same
// packing step. Input ready is low while an encode or flush waits for
// that step, and while a second byte is queued behind the output register.
// Encodes of up to 16-bit codes give at most two bytes; the second waits in
// a hold register, and no request is taken while it waits.
// Reset clears the pending bits and the output; the table holds garbage until
// each entry is loaded, and no clearing pass runs.
// When the receiver stalls, the output byte holds and the packing step waits
// for the output register to free up, so input ready stays low meanwhile.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module huffman_code_bit_packer_top #(
  parameter int unsigned MAX_CODE_LEN  = hcbp_pkg::MAX_CODE_LEN_DEF,
  parameter int unsigned ALPHABET_SIZE = hcbp_pkg::ALPHABET_SIZE_DEF
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  hcbp_in_if.sink     in_i,
  hcbp_out_if.source  out_o
);

  localparam int unsigned LenLim = (MAX_CODE_LEN < hcbp_pkg::CODE_FIELD_W) ?
                                   MAX_CODE_LEN : hcbp_pkg::CODE_FIELD_W;
  localparam int unsigned LenW   = $clog2(LenLim + 1);
  localparam int unsigned EntryW = LenW + LenLim;
  localparam int unsigned AddrW  = $clog2(ALPHABET_SIZE);
  localparam int unsigned AccW   = hcbp_pkg::PEND_W + LenLim;
  localparam int unsigned SymExtW = hcbp_pkg::SYM_W + 1;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic                              state_q, state_d;
  logic [hcbp_pkg::REQ_W-1:0]        req_q;
  logic [hcbp_pkg::PEND_W-1:0]       pend_bits_q, pend_bits_d;
  logic [hcbp_pkg::CNT_W-1:0]        pend_cnt_q, pend_cnt_d;
  logic                              out_valid_q, out_valid_d;
  logic [hcbp_pkg::BYTE_W-1:0]       out_byte_q, out_byte_d;
  logic                              out_last_q, out_last_d;
  logic                              hold_valid_q, hold_valid_d;
  logic [hcbp_pkg::BYTE_W-1:0]       hold_byte_q, hold_byte_d;

  logic                              in_fire;
  logic                              sym_ok;
  logic                              slot_free;
  logic                              exec_go;

  logic [hcbp_pkg::LEN_FIELD_W-1:0]  ld_len;
  logic [hcbp_pkg::CODE_FIELD_W-1:0] ld_mask;
  logic [hcbp_pkg::CODE_FIELD_W-1:0] ld_code;
  logic                              tbl_wr_en;
  logic                              tbl_rd_en;
  logic [EntryW-1:0]                 tbl_wr_data;
  logic [EntryW-1:0]                 tbl_rd_data;

  logic [hcbp_pkg::TOT_W-1:0]        clen;
  logic [LenLim-1:0]                 code;
  logic [AccW-1:0]                   acc;
  logic [hcbp_pkg::TOT_W-1:0]        total;
  logic [hcbp_pkg::TOT_W-1:0]        sh0, sh1;
  logic [hcbp_pkg::BYTE_W-1:0]       byte0, byte1;
  logic [hcbp_pkg::PEND_W-1:0]       rem_mask;
  logic [hcbp_pkg::PEND_W-1:0]       rem_bits;
  logic [hcbp_pkg::CNT_W:0]          fl_shift;
  logic [hcbp_pkg::BYTE_W-1:0]       fl_byte;

  // input handshake
  assign in_i.ready = (state_q == S_IDLE) && !hold_valid_q;
  assign in_fire    = in_i.valid && in_i.ready;
  assign sym_ok     = {1'b0, in_i.symbol} < SymExtW'(ALPHABET_SIZE);

  // load entry: clamp the length and drop code bits above it
  always_comb begin
    ld_len  = (in_i.code_len > hcbp_pkg::LEN_FIELD_W'(LenLim)) ?
              hcbp_pkg::LEN_FIELD_W'(LenLim) : in_i.code_len;
    ld_mask = ~({hcbp_pkg::CODE_FIELD_W{1'b1}} << ld_len);
    ld_code = in_i.code_bits & ld_mask;
  end

  assign tbl_wr_en   = in_fire && (in_i.req_type == hcbp_pkg::REQ_LOAD) && sym_ok;
  assign tbl_rd_en   = in_fire && (in_i.req_type == hcbp_pkg::REQ_ENCODE) && sym_ok;
  assign tbl_wr_data = {ld_len[LenW-1:0], ld_code[LenLim-1:0]};

  // code table; a load and a later encode never touch it in the same cycle
  hcbp_ram #(
    .WIDTH (EntryW),
    .DEPTH (ALPHABET_SIZE)
  ) u_table (
    .clk_i     (clk_i),
    .wr_en_i   (tbl_wr_en),
    .wr_addr_i (in_i.symbol[AddrW-1:0]),
    .wr_data_i (tbl_wr_data),
    .rd_en_i   (tbl_rd_en),
    .rd_addr_i (in_i.symbol[AddrW-1:0]),
    .rd_data_o (tbl_rd_data)
  );

  // append the code to the pending bits and cut out whole bytes
  always_comb begin
    clen     = hcbp_pkg::TOT_W'(tbl_rd_data[EntryW-1 -: LenW]);
    code     = tbl_rd_data[LenLim-1:0];
    acc      = (AccW'(pend_bits_q) << clen) | AccW'(code);
    total    = hcbp_pkg::TOT_W'(pend_cnt_q) + clen;
    sh0      = total - hcbp_pkg::TOT_W'(hcbp_pkg::BYTE_W);
    sh1      = total - hcbp_pkg::TOT_W'(2 * hcbp_pkg::BYTE_W);
    byte0    = hcbp_pkg::BYTE_W'(acc >> sh0);
    byte1    = hcbp_pkg::BYTE_W'(acc >> sh1);
    rem_mask = ~({hcbp_pkg::PEND_W{1'b1}} << total[hcbp_pkg::CNT_W-1:0]);
    rem_bits = hcbp_pkg::PEND_W'(acc) & rem_mask;
    fl_shift = (hcbp_pkg::CNT_W + 1)'(hcbp_pkg::BYTE_W) - {1'b0, pend_cnt_q};
    fl_byte  = hcbp_pkg::BYTE_W'(pend_bits_q) << fl_shift;
  end

  assign slot_free = !out_valid_q || out_o.ready;
  assign exec_go   = (state_q == S_EXEC) && slot_free;

  // sequencer, packer state and output register
  always_comb begin
    state_d      = state_q;
    pend_bits_d  = pend_bits_q;
    pend_cnt_d   = pend_cnt_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    out_byte_d   = out_byte_q;
    out_last_d   = out_last_q;
    hold_valid_d = hold_valid_q;
    hold_byte_d  = hold_byte_q;

    if (in_fire) begin
      if (((in_i.req_type == hcbp_pkg::REQ_ENCODE) && sym_ok) ||
          (in_i.req_type == hcbp_pkg::REQ_FLUSH)) begin
        state_d = S_EXEC;
      end
    end

    // queued second byte goes first
    if (slot_free && hold_valid_q) begin
      out_valid_d  = 1'b1;
      out_byte_d   = hold_byte_q;
      out_last_d   = 1'b1;
      hold_valid_d = 1'b0;
    end

    if (exec_go) begin
      state_d = S_IDLE;
      case (req_q)
        hcbp_pkg::REQ_ENCODE: begin
          if (clen != '0) begin
            pend_bits_d = rem_bits;
            pend_cnt_d  = total[hcbp_pkg::CNT_W-1:0];
            if (total >= hcbp_pkg::TOT_W'(hcbp_pkg::BYTE_W)) begin
              out_valid_d = 1'b1;
              out_byte_d  = byte0;
              out_last_d  = 1'b1;
            end
            if (total >= hcbp_pkg::TOT_W'(2 * hcbp_pkg::BYTE_W)) begin
              out_last_d   = 1'b0;
              hold_valid_d = 1'b1;
              hold_byte_d  = byte1;
            end
          end
        end
        hcbp_pkg::REQ_FLUSH: begin
          if (pend_cnt_q != '0) begin
            out_valid_d = 1'b1;
            out_byte_d  = fl_byte;
            out_last_d  = 1'b1;
            pend_bits_d = '0;
            pend_cnt_d  = '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      pend_bits_q  <= '0;
      pend_cnt_q   <= '0;
      out_valid_q  <= 1'b0;
      hold_valid_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      pend_bits_q  <= pend_bits_d;
      pend_cnt_q   <= pend_cnt_d;
      out_valid_q  <= out_valid_d;
      hold_valid_q <= hold_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    out_byte_q  <= out_byte_d;
    out_last_q  <= out_last_d;
    hold_byte_q <= hold_byte_d;
    if (in_fire) begin
      req_q <= in_i.req_type;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.packed_byte = out_byte_q;
  assign out_o.is_last     = out_last_q;

  // a queued second byte always sits behind a valid first byte
  `ASSERT_ALWAYS(a_hold_behind_out, clk_i, rst_ni, !hold_valid_q || out_valid_q)

  // pending bits never reach above the pending count
  `ASSERT_ALWAYS(a_pend_aligned, clk_i, rst_ni,
    (hcbp_pkg::PEND_W'(pend_bits_q >> pend_cnt_q) == '0))

  // an encode in range always goes on to the packing step
  `ASSERT_NEXT(a_encode_exec, clk_i, rst_ni,
    in_fire && (in_i.req_type == hcbp_pkg::REQ_ENCODE) && sym_ok,
    state_q == S_EXEC)

  // a queued byte is kept while the receiver stalls
  `ASSERT_NEXT(a_hold_kept, clk_i, rst_ni,
    hold_valid_q && out_valid_q && !out_o.ready,
    hold_valid_q && $stable(hold_byte_q))

endmodule

`default_nettype wire
